// ===== rtl/rrt_pkg.sv =====
package rrt_pkg;

	localparam int TABLE_SLOTS = 32;
	localparam int KEY_BITS = 16;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int FAIL_W = $clog2(TABLE_SLOTS + 1);

	// Depth of the command queue between the front and the back; a power of two.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_MATCH    = 2'd1,
		CMD_SWEEP    = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_REGISTER = 2'd0,
		KIND_MATCH    = 2'd1,
		KIND_RETRY    = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef struct packed {
		cmd_t        op;
		key_t        key;
		logic        fmt;
		logic [7:0]  budget;
		logic        mark;
		logic [31:0] now;
	} cmd_item_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] sent;
		logic [7:0]  left;
		logic        wd;
		logic        fmt;
	} entry_t;

endpackage

// ===== rtl/rrt_if.sv =====
interface rrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] request_key;
	logic        request_format;
	logic [7:0]  retry_budget;
	logic        watchdog_mark;
	logic [31:0] now_ms;

	modport source (
		output valid, command, request_key, request_format, retry_budget, watchdog_mark,
		       now_ms,
		input  ready
	);
	modport sink (
		input  valid, command, request_key, request_format, retry_budget, watchdog_mark,
		       now_ms,
		output ready
	);
endinterface

interface rrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic        success;
	logic [4:0]  slot_index;
	logic [15:0] retry_key;
	logic        retry_format;
	logic [5:0]  watchdog_failures;
	logic        last;

	modport source (
		output valid, result_kind, success, slot_index, retry_key, retry_format,
		       watchdog_failures, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, success, slot_index, retry_key, retry_format,
		       watchdog_failures, last,
		output ready
	);
endinterface

// ===== rtl/rrt_ram.sv =====
module rrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rrt_front.sv =====
module rrt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	rrt_req_if.sink               req,
	output logic                  item_vld,
	output rrt_pkg::cmd_item_t    item,
	input  logic                  item_pop
);

	rrt_pkg::cmd_item_t              q_mem_q [rrt_pkg::QDEPTH];
	logic [rrt_pkg::QPTR_W-1:0]      wptr_q;
	logic [rrt_pkg::QPTR_W-1:0]      rptr_q;
	logic [rrt_pkg::QCNT_W-1:0]      cnt_q;
	rrt_pkg::cmd_item_t              in_item;
	logic                            push;
	logic                            pop;

	// Decode the raw command and fold the key into its stored width.
	always_comb begin
		in_item.op     = rrt_pkg::cmd_t'(req.command);
		in_item.key    = rrt_pkg::KEY_BITS'(req.request_key);
		in_item.fmt    = req.request_format;
		in_item.budget = req.retry_budget;
		in_item.mark   = req.watchdog_mark;
		in_item.now    = req.now_ms;
	end

	assign req.ready = (cnt_q != rrt_pkg::QCNT_W'(rrt_pkg::QDEPTH));
	assign push      = req.valid && req.ready;
	assign item_vld  = (cnt_q != '0);
	assign pop       = item_pop && item_vld;
	assign item      = q_mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + rrt_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + rrt_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + rrt_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - rrt_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wptr_q] <= in_item;
		end
	end

endmodule

// ===== rtl/rrt_back.sv =====
module rrt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               item_vld,
	input  rrt_pkg::cmd_item_t item,
	output logic               item_pop,
	rrt_rsp_if.source          rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_SUM  = 3'b100
	} state_t;

	state_t                               state_q, state_d;
	logic [15:0]                          timeout_q;
	logic [rrt_pkg::TABLE_SLOTS-1:0]      valid_q;
	logic [rrt_pkg::TABLE_SLOTS-1:0]      valid_set, valid_clr;
	logic                                 clear_all;
	logic [rrt_pkg::IDX_W-1:0]            eval_idx_q, idx_d;
	logic [rrt_pkg::FAIL_W-1:0]           fail_q, fail_d;
	rrt_pkg::cmd_item_t                   cur_q;
	logic                                 latch;

	logic                                 ram_we;
	logic [rrt_pkg::IDX_W-1:0]            ram_waddr, ram_raddr;
	rrt_pkg::entry_t                      ram_wdata, rdata;

	logic [rrt_pkg::TABLE_SLOTS-1:0]      free_vec, lowest;
	logic                                 any_free;
	logic [rrt_pkg::IDX_W-1:0]            free_idx;
	logic                                 slot_vld, due, key_hit, last_slot, step, slot_done;
	logic [31:0]                          age;

	logic                                 out_free, ld;
	rrt_pkg::kind_t                       ld_kind;
	logic                                 ld_succ, ld_fmt, ld_last;
	logic [rrt_pkg::IDX_W-1:0]            ld_idx;
	logic [15:0]                          ld_key;
	logic [rrt_pkg::FAIL_W-1:0]           ld_fail;

	logic                                 out_vld_q;
	rrt_pkg::kind_t                       out_kind_q;
	logic                                 out_succ_q, out_fmt_q, out_last_q;
	logic [4:0]                           out_idx_q;
	logic [15:0]                          out_key_q;
	logic [5:0]                           out_fail_q;

	rrt_ram #(
		.WIDTH($bits(rrt_pkg::entry_t)),
		.DEPTH(rrt_pkg::TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Lowest free slot: isolate the lowest set bit, then encode it.
	always_comb begin
		free_vec = ~valid_q;
		lowest   = free_vec & (~free_vec + rrt_pkg::TABLE_SLOTS'(1));
		any_free = |free_vec;
		free_idx = '0;
		for (int j = 0; j < rrt_pkg::TABLE_SLOTS; j++) begin
			if (lowest[j]) begin
				free_idx = free_idx | rrt_pkg::IDX_W'(j);
			end
		end
	end

	assign slot_vld  = valid_q[eval_idx_q];
	assign age       = cur_q.now - rdata.sent;
	assign due       = slot_vld && (age >= {16'd0, timeout_q});
	assign key_hit   = slot_vld && (rdata.key == cur_q.key);
	assign last_slot = (eval_idx_q == rrt_pkg::IDX_W'(rrt_pkg::TABLE_SLOTS - 1));
	assign out_free  = !out_vld_q || rsp.ready;

	always_comb begin
		item_pop  = 1'b0;
		latch     = 1'b0;
		ld        = 1'b0;
		ld_kind   = rrt_pkg::KIND_REGISTER;
		ld_succ   = 1'b0;
		ld_idx    = '0;
		ld_key    = '0;
		ld_fmt    = 1'b0;
		ld_fail   = '0;
		ld_last   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = free_idx;
		ram_raddr = '0;
		ram_wdata.key  = item.key;
		ram_wdata.sent = item.now;
		ram_wdata.left = item.budget;
		ram_wdata.wd   = item.mark;
		ram_wdata.fmt  = item.fmt;
		state_d   = state_q;
		idx_d     = eval_idx_q;
		fail_d    = fail_q;
		valid_set = '0;
		valid_clr = '0;
		clear_all = 1'b0;
		step      = 1'b0;
		slot_done = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (item_vld && out_free) begin
					item_pop = 1'b1;
					case (item.op)
						rrt_pkg::CMD_REGISTER: begin
							ld      = 1'b1;
							ld_kind = rrt_pkg::KIND_REGISTER;
							ld_last = 1'b1;
							if (any_free) begin
								ld_succ   = 1'b1;
								ld_idx    = free_idx;
								ram_we    = 1'b1;
								valid_set = lowest;
							end
						end
						rrt_pkg::CMD_MATCH, rrt_pkg::CMD_SWEEP: begin
							// Slot 0 is read in this cycle and evaluated in the next.
							latch   = 1'b1;
							idx_d   = '0;
							fail_d  = '0;
							state_d = ST_WALK;
						end
						rrt_pkg::CMD_CLEAR: begin
							ld        = 1'b1;
							ld_kind   = rrt_pkg::KIND_DONE;
							ld_last   = 1'b1;
							clear_all = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				// Re-reading the slot under evaluation keeps its data in place on a stall.
				ram_raddr      = eval_idx_q;
				ram_waddr      = eval_idx_q;
				ram_wdata      = rdata;
				ram_wdata.left = rdata.left - 8'd1;
				ram_wdata.sent = cur_q.now;
				if (cur_q.op == rrt_pkg::CMD_MATCH) begin
					if (key_hit || last_slot) begin
						if (out_free) begin
							ld      = 1'b1;
							ld_kind = rrt_pkg::KIND_MATCH;
							ld_last = 1'b1;
							state_d = ST_IDLE;
							if (key_hit) begin
								ld_succ   = 1'b1;
								ld_idx    = eval_idx_q;
								valid_clr = rrt_pkg::TABLE_SLOTS'(1) << eval_idx_q;
							end
						end
					end else begin
						step = 1'b1;
					end
				end else begin
					if (due) begin
						if (rdata.left == 8'd0) begin
							valid_clr = rrt_pkg::TABLE_SLOTS'(1) << eval_idx_q;
							if (rdata.wd) begin
								fail_d = fail_q + rrt_pkg::FAIL_W'(1);
							end
						end else if (out_free) begin
							ld      = 1'b1;
							ld_kind = rrt_pkg::KIND_RETRY;
							ld_idx  = eval_idx_q;
							ld_key  = 16'(rdata.key);
							ld_fmt  = rdata.fmt;
							ram_we  = 1'b1;
						end else begin
							slot_done = 1'b0;
						end
					end
					if (slot_done) begin
						if (last_slot) begin
							state_d = ST_SUM;
						end else begin
							step = 1'b1;
						end
					end
				end
				if (step) begin
					idx_d     = eval_idx_q + rrt_pkg::IDX_W'(1);
					ram_raddr = eval_idx_q + rrt_pkg::IDX_W'(1);
				end
			end
			ST_SUM: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = rrt_pkg::KIND_DONE;
					ld_fail = fail_q;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= rrt_pkg::TIMEOUT_RESET;
			valid_q    <= '0;
			state_q    <= ST_IDLE;
			eval_idx_q <= '0;
			fail_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (clear_all) begin
				valid_q <= '0;
			end else begin
				valid_q <= (valid_q | valid_set) & ~valid_clr;
			end
			state_q    <= state_d;
			eval_idx_q <= idx_d;
			fail_q     <= fail_d;
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch) begin
			cur_q <= item;
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_succ_q <= ld_succ;
			out_idx_q  <= 5'(ld_idx);
			out_key_q  <= ld_key;
			out_fmt_q  <= ld_fmt;
			out_fail_q <= 6'(ld_fail);
			out_last_q <= ld_last;
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.result_kind       = out_kind_q;
	assign rsp.success           = out_succ_q;
	assign rsp.slot_index        = out_idx_q;
	assign rsp.retry_key         = out_key_q;
	assign rsp.retry_format      = out_fmt_q;
	assign rsp.watchdog_failures = out_fail_q;
	assign rsp.last              = out_last_q;

	a_retry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_kind_q == rrt_pkg::KIND_RETRY) |-> !out_last_q)
		else $error("retry item marked as last");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.op == rrt_pkg::CMD_CLEAR) |=> (valid_q == '0))
		else $error("clear left a valid slot");

	a_register_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.op == rrt_pkg::CMD_REGISTER && any_free)
		|=> valid_q[$past(free_idx)])
		else $error("registered slot not valid");

	a_match_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_kind == rrt_pkg::KIND_MATCH && ld_succ) |=> !valid_q[$past(eval_idx_q)])
		else $error("matched slot still valid");

endmodule

// ===== rtl/request_retry_timeout_table_core.sv =====
// Request retry and timeout table.
// Input items arrive on req (valid/ready); each one carries a command: register,
// match, sweep or clear. Result items leave on rsp (valid/ready); the last result
// of an input item has last set. The timeout is written through cfg_we/cfg_wdata.
// A two-entry command queue sits in front of the execution unit, so items are
// accepted while earlier ones are still being worked on or their results wait.
// Register and clear are taken from the queue and their result is loaded into the
// output register. Match walks the slot memory one slot per cycle and stops at
// the first hit or at the last slot. A sweep visits every slot, one per cycle
// while no retry waits on rsp, then emits its summary, the single read port of
// the slot memory setting that pace.
// A stalled rsp holds the current result; the walk waits on any slot that must
// emit a retry, while expiring slots keep moving.
// Reset empties the table and the queue and sets the timeout to 1500 ms; no
// clearing pass is needed, since slot contents are only read behind valid bits.
module request_retry_timeout_table_core (
	input  logic        clk,
	input  logic        arst_n,
	rrt_req_if.sink     req,
	rrt_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic               item_vld;
	logic               item_pop;
	rrt_pkg::cmd_item_t item;

	rrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.item_vld (item_vld),
		.item     (item),
		.item_pop (item_pop)
	);

	rrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_vld  (item_vld),
		.item      (item),
		.item_pop  (item_pop),
		.rsp       (rsp)
	);

endmodule
